// ===== rtl/pscs_pkg.sv =====
// -----------------------------------------------------------------------------
// pscs_pkg
// Shared sizes, codes and types of the page striping command splitter.
// -----------------------------------------------------------------------------
package pscs_pkg;

   // Sizing
   localparam int QUEUE_SLOTS    = 32;
   localparam int MAX_CMD_PAGES  = 64;
   localparam int MAX_DICE       = 64;
   localparam int JOB_FIFO_DEPTH = 4;

   // Field widths
   localparam int TAG_W    = $clog2(QUEUE_SLOTS);
   localparam int COUNT_W  = 7;
   localparam int PAGE_W   = 32;
   localparam int DIE_W    = 6;
   localparam int DCNT_W   = 7;
   localparam int LIMIT_W  = 6;
   localparam int HDR_W    = 12;
   localparam int PBYTES_W = 17;
   localparam int RBYTES_W = 24;
   localparam int OUTST_W  = $clog2(QUEUE_SLOTS + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int DIV_CNT_W  = $clog2(PAGE_W);

   // Input opcodes
   localparam logic [1:0] OP_HOST_CMD  = 2'd0;
   localparam logic [1:0] OP_PAGE_DONE = 2'd1;
   localparam logic [1:0] OP_RET_SENT  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_SUB    = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BYTES   = 2'd3;

   // Configuration as seen by the front and back parts
   typedef struct packed {
      logic [DCNT_W-1:0]   die_count;
      logic [LIMIT_W-1:0]  queue_limit;
      logic [HDR_W-1:0]    header_bytes;
      logic [PBYTES_W-1:0] page_bytes;
   } csr_type;

   // One classified job: either a command to split or a single result
   typedef struct packed {
      logic                split;
      logic [1:0]          kind;
      logic                is_write;
      logic [TAG_W-1:0]    tag;
      logic [PAGE_W-1:0]   start_page;
      logic [COUNT_W-1:0]  page_count;
      logic                priority_bit;
   } job_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back part sequencer
   typedef enum logic [3:0] {
      BK_IDLE   = 4'b0001,
      BK_DIVIDE = 4'b0010,
      BK_SPLIT  = 4'b0100,
      BK_SINGLE = 4'b1000
   } back_state_type;

endpackage

// ===== rtl/page_striping_command_splitter.sv =====
// -----------------------------------------------------------------------------
// page_striping_command_splitter
// Host command front end: admits, stripes and completes commands.
// -----------------------------------------------------------------------------
// Timing: the front accepts one event per cycle while its four-entry job
// queue has room; page-done events that leave pages open and good
// return-sent events end there. In the back part an admitted host command
// leaves the queue, passes through the bit-serial divider (start page by die
// count), then yields one sub-request per page, one per cycle while the output
// register is free. A completion, rejection or error passes through the idle
// and single states of the back part. The output register lets the back part
// load the next result while the current one is being taken.
// -----------------------------------------------------------------------------
module page_striping_command_splitter import pscs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,  // is_write, start_page, page_count, tag
   input  logic [1:0]            req_tuser,  // opcode
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,  // die_num, die_page, sub_is_write,
                                             // out_tag, return_priority, return_bytes
   output logic [1:0]            rsp_tuser,  // kind
   output logic                  rsp_tlast,  // last
   // configuration writes
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type            cfg_ff;
   job_type            push_job;
   job_type            pop_job;
   logic               push;
   logic               pop;
   queue_status_type   queue_status;

   logic [DIE_W-1:0]    die_num;
   logic [PAGE_W-1:0]   die_page;
   logic                sub_is_write;
   logic [TAG_W-1:0]    out_tag;
   logic                return_priority;
   logic [RBYTES_W-1:0] return_bytes;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.die_count    <= DCNT_W'(8);
         cfg_ff.queue_limit  <= LIMIT_W'(32);
         cfg_ff.header_bytes <= HDR_W'(16);
         cfg_ff.page_bytes   <= PBYTES_W'(4096);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DIE_COUNT:    cfg_ff.die_count    <= csr_wdata[DCNT_W-1:0];
            CSR_QUEUE_LIMIT:  cfg_ff.queue_limit  <= csr_wdata[LIMIT_W-1:0];
            CSR_HEADER_BYTES: cfg_ff.header_bytes <= csr_wdata[HDR_W-1:0];
            CSR_PAGE_BYTES:   cfg_ff.page_bytes   <= csr_wdata[PBYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pscs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_opcode     (req_tuser),
      .req_is_write   (req_tdata[0]),
      .req_start_page (req_tdata[32:1]),
      .req_page_count (req_tdata[39:33]),
      .req_tag        (req_tdata[44:40]),
      .cfg            (cfg_ff),
      .queue_status   (queue_status),
      .push           (push),
      .push_job       (push_job)
   );

   pscs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (queue_status)
   );

   pscs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .queue_status        (queue_status),
      .pop_job             (pop_job),
      .pop                 (pop),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_kind            (rsp_tuser),
      .rsp_die_num         (die_num),
      .rsp_die_page        (die_page),
      .rsp_sub_is_write    (sub_is_write),
      .rsp_out_tag         (out_tag),
      .rsp_return_priority (return_priority),
      .rsp_return_bytes    (return_bytes),
      .rsp_last            (rsp_tlast)
   );

   // Pack result payload, highest field first (die_num in the lowest bits)
   assign rsp_tdata = {3'b000, return_bytes, return_priority, out_tag,
                       sub_is_write, die_page, die_num};

endmodule

// ===== rtl/pscs_front.sv =====
// -----------------------------------------------------------------------------
// pscs_front
// Accepts events, checks them against per-tag and queue state, updates that
// state and pushes one job per event that produces results.
// -----------------------------------------------------------------------------
module pscs_front import pscs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic                req_is_write,
   input  logic [PAGE_W-1:0]   req_start_page,
   input  logic [COUNT_W-1:0]  req_page_count,
   input  logic [TAG_W-1:0]    req_tag,
   input  csr_type             cfg,
   input  queue_status_type    queue_status,
   output logic                push,
   output job_type             push_job
);

   logic [COUNT_W-1:0] remaining_ff [QUEUE_SLOTS];
   logic               slot_wr_ff   [QUEUE_SLOTS];
   logic [COUNT_W-1:0] slot_cnt_ff  [QUEUE_SLOTS];
   logic [OUTST_W-1:0] outst_ff;
   logic [OUTST_W-1:0] outst_in;

   logic               accept;
   logic [COUNT_W-1:0] rem_cur;
   logic [LIMIT_W-1:0] limit;
   logic               cmd_bad;
   logic               want_push;
   logic               rem_we;
   logic [COUNT_W-1:0] rem_wdata;
   logic               slot_we;
   logic               outst_inc;
   logic               outst_dec;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign rem_cur   = remaining_ff[req_tag];
   assign limit     = (cfg.queue_limit > LIMIT_W'(QUEUE_SLOTS)) ?
                      LIMIT_W'(QUEUE_SLOTS) : cfg.queue_limit;
   assign cmd_bad   = (req_page_count == '0) ||
                      (req_page_count > COUNT_W'(MAX_CMD_PAGES)) ||
                      (rem_cur != '0);

   // Classify the event
   always_comb begin
      push_job.split        = 1'b0;
      push_job.kind         = KIND_ERROR;
      push_job.is_write     = 1'b0;
      push_job.tag          = req_tag;
      push_job.start_page   = req_start_page;
      push_job.page_count   = req_page_count;
      push_job.priority_bit = 1'b0;
      want_push = 1'b0;
      rem_we    = 1'b0;
      rem_wdata = req_page_count;
      slot_we   = 1'b0;
      outst_inc = 1'b0;
      outst_dec = 1'b0;
      case (req_opcode)
         OP_HOST_CMD: begin
            want_push = 1'b1;
            if (cmd_bad) begin
               push_job.kind = KIND_ERROR;
            end else if (outst_ff >= OUTST_W'(limit)) begin
               push_job.kind     = KIND_REJECT;
               push_job.is_write = req_is_write;
            end else begin
               push_job.split    = 1'b1;
               push_job.kind     = KIND_SUB;
               push_job.is_write = req_is_write;
               rem_we    = 1'b1;
               slot_we   = 1'b1;
               outst_inc = 1'b1;
            end
         end
         OP_PAGE_DONE: begin
            if (rem_cur == '0) begin
               want_push = 1'b1;
            end else begin
               rem_we    = 1'b1;
               rem_wdata = rem_cur - COUNT_W'(1);
               if (rem_cur == COUNT_W'(1)) begin
                  want_push             = 1'b1;
                  push_job.kind         = KIND_DONE;
                  push_job.is_write     = slot_wr_ff[req_tag];
                  push_job.page_count   = slot_cnt_ff[req_tag];
                  push_job.priority_bit = !slot_wr_ff[req_tag];
               end
            end
         end
         OP_RET_SENT: begin
            if (outst_ff == '0) begin
               want_push = 1'b1;
            end else begin
               outst_dec = 1'b1;
            end
         end
         default: begin
            want_push = 1'b1;
         end
      endcase
   end

   assign push = accept && want_push;

   always_comb begin
      outst_in = outst_ff;
      if (accept && outst_inc) begin
         outst_in = outst_ff + OUTST_W'(1);
      end else if (accept && outst_dec) begin
         outst_in = outst_ff - OUTST_W'(1);
      end
   end

   // Per-tag open page count and outstanding command count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            remaining_ff[i] <= '0;
         end
         outst_ff <= '0;
      end else begin
         if (accept && rem_we) begin
            remaining_ff[req_tag] <= rem_wdata;
         end
         outst_ff <= outst_in;
      end
   end

   // Per-tag command type and size, written on admission
   always_ff @(posedge clock) begin
      if (accept && slot_we) begin
         slot_wr_ff[req_tag]  <= req_is_write;
         slot_cnt_ff[req_tag] <= req_page_count;
      end
   end

endmodule

// ===== rtl/pscs_queue.sv =====
// -----------------------------------------------------------------------------
// pscs_queue
// Short job queue that decouples classification from result generation.
// -----------------------------------------------------------------------------
module pscs_queue import pscs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          pop_job,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(JOB_FIFO_DEPTH);
   localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

   job_type          mem_ff [JOB_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (cnt_ff == CNT_W'(JOB_FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(JOB_FIFO_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(JOB_FIFO_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/pscs_back.sv =====
// -----------------------------------------------------------------------------
// pscs_back
// Takes jobs from the queue. A command is divided once by the die count (one
// quotient bit per cycle), then walked page by page, one sub-request per cycle
// if output is free; singles go out directly. Owns the result output register.
// -----------------------------------------------------------------------------
module pscs_back import pscs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  csr_type              cfg,
   input  queue_status_type     queue_status,
   input  job_type              pop_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [DIE_W-1:0]     rsp_die_num,
   output logic [PAGE_W-1:0]    rsp_die_page,
   output logic                 rsp_sub_is_write,
   output logic [TAG_W-1:0]     rsp_out_tag,
   output logic                 rsp_return_priority,
   output logic [RBYTES_W-1:0]  rsp_return_bytes,
   output logic                 rsp_last
);

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   logic [RBYTES_W-1:0]   prod_ff, prod_in;
   logic [DCNT_W-1:0]     dc_ff, dc_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [PAGE_W-1:0]     quot_ff, quot_in;
   logic [DCNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0]    left_ff, left_in;

   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff, out_kind_in;
   logic [DIE_W-1:0]      out_die_ff, out_die_in;
   logic [PAGE_W-1:0]     out_dpage_ff, out_dpage_in;
   logic                  out_wr_ff, out_wr_in;
   logic [TAG_W-1:0]      out_tag_ff, out_tag_in;
   logic                  out_prio_ff, out_prio_in;
   logic [RBYTES_W-1:0]   out_bytes_ff, out_bytes_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;
   logic                  out_load;
   logic [DCNT_W-1:0]     dc_eff;
   logic [DCNT_W-1:0]     trial;
   logic                  trial_ge;

   assign out_free = !out_valid_ff || rsp_ready;

   // Clamp die count into the supported range
   always_comb begin
      dc_eff = cfg.die_count;
      if (cfg.die_count == '0) begin
         dc_eff = DCNT_W'(1);
      end else if (cfg.die_count > DCNT_W'(MAX_DICE)) begin
         dc_eff = DCNT_W'(MAX_DICE);
      end
   end

   // One restoring division step
   assign trial    = {rem_ff[DCNT_W-2:0], quot_ff[PAGE_W-1]};
   assign trial_ge = (trial >= dc_ff);

   // Sequence jobs
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      prod_in  = prod_ff;
      dc_in    = dc_ff;
      page_in  = page_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      out_kind_in  = out_kind_ff;
      out_die_in   = out_die_ff;
      out_dpage_in = out_dpage_ff;
      out_wr_in    = out_wr_ff;
      out_tag_in   = out_tag_ff;
      out_prio_in  = out_prio_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               pop    = 1'b1;
               job_in = pop_job;
               if (pop_job.split) begin
                  dc_in    = dc_eff;
                  page_in  = pop_job.start_page;
                  quot_in  = pop_job.start_page;
                  rem_in   = '0;
                  step_in  = DIV_CNT_W'(PAGE_W - 1);
                  left_in  = pop_job.page_count;
                  state_in = BK_DIVIDE;
               end else begin
                  prod_in  = (pop_job.kind == KIND_DONE && !pop_job.is_write) ?
                             RBYTES_W'(pop_job.page_count) * RBYTES_W'(cfg.page_bytes) :
                             '0;
                  state_in = BK_SINGLE;
               end
            end
         end
         BK_DIVIDE: begin
            quot_in = {quot_ff[PAGE_W-2:0], trial_ge};
            rem_in  = trial_ge ? trial - dc_ff : trial;
            step_in = step_ff - DIV_CNT_W'(1);
            if (step_ff == '0) begin
               state_in = BK_SPLIT;
            end
         end
         BK_SPLIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_kind_in  = KIND_SUB;
               out_die_in   = rem_ff[DIE_W-1:0];
               out_dpage_in = quot_ff;
               out_wr_in    = job_ff.is_write;
               out_tag_in   = job_ff.tag;
               out_prio_in  = 1'b0;
               out_bytes_in = '0;
               out_last_in  = (left_ff == COUNT_W'(1));
               // step to the next page, wrapping the page address
               page_in = page_ff + PAGE_W'(1);
               left_in = left_ff - COUNT_W'(1);
               if (page_ff == '1) begin
                  quot_in = '0;
                  rem_in  = '0;
               end else if (rem_ff + DCNT_W'(1) == dc_ff) begin
                  quot_in = quot_ff + PAGE_W'(1);
                  rem_in  = '0;
               end else begin
                  rem_in  = rem_ff + DCNT_W'(1);
               end
               if (left_ff == COUNT_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_SINGLE: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_kind_in  = job_ff.kind;
               out_die_in   = '0;
               out_dpage_in = '0;
               out_wr_in    = job_ff.is_write;
               out_tag_in   = job_ff.tag;
               out_prio_in  = job_ff.priority_bit;
               out_bytes_in = (job_ff.kind == KIND_DONE) ?
                              RBYTES_W'(cfg.header_bytes) + prod_ff : '0;
               out_last_in  = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      prod_ff      <= prod_in;
      dc_ff        <= dc_in;
      page_ff      <= page_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      left_ff      <= left_in;
      out_kind_ff  <= out_kind_in;
      out_die_ff   <= out_die_in;
      out_dpage_ff <= out_dpage_in;
      out_wr_ff    <= out_wr_in;
      out_tag_ff   <= out_tag_in;
      out_prio_ff  <= out_prio_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_die_num         = out_die_ff;
   assign rsp_die_page        = out_dpage_ff;
   assign rsp_sub_is_write    = out_wr_ff;
   assign rsp_out_tag         = out_tag_ff;
   assign rsp_return_priority = out_prio_ff;
   assign rsp_return_bytes    = out_bytes_ff;
   assign rsp_last            = out_last_ff;

endmodule

// ===== sim/pscs_result_checker.sv =====
// -----------------------------------------------------------------------------
// pscs_result_checker
// Watches the request, result and register ports of the command splitter,
// predicts the results of every accepted request transfer and compares each
// accepted result transfer, field by field, with the oldest prediction.
// -----------------------------------------------------------------------------
module pscs_result_checker import pscs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [71:0]           rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending
);

   typedef struct packed {
      logic [1:0]          kind;
      logic [DIE_W-1:0]    die_num;
      logic [PAGE_W-1:0]   die_page;
      logic                is_write;
      logic [TAG_W-1:0]    tag;
      logic                priority_bit;
      logic [RBYTES_W-1:0] return_bytes;
      logic                last;
   } stripe_result_type;

   stripe_result_type expected_results[$];
   int                fail_count;

   // Register copies
   logic [DCNT_W-1:0]   cfg_die_count;
   logic [LIMIT_W-1:0]  cfg_queue_limit;
   logic [HDR_W-1:0]    cfg_header_bytes;
   logic [PBYTES_W-1:0] cfg_page_bytes;

   // Command slot bookkeeping
   logic [COUNT_W-1:0]  pages_open   [QUEUE_SLOTS];
   logic                slot_write   [QUEUE_SLOTS];
   logic [COUNT_W-1:0]  slot_pages   [QUEUE_SLOTS];
   int unsigned         commands_out;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Append one prediction at the tail
   task automatic queue_expected(stripe_result_type r);
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic clear_model();
      int k;
      cfg_die_count    = 7'd8;
      cfg_queue_limit  = 6'd32;
      cfg_header_bytes = 12'd16;
      cfg_page_bytes   = 17'd4096;
      for (k = 0; k < QUEUE_SLOTS; k++) begin
         pages_open[k] = '0;
         slot_write[k] = 1'b0;
         slot_pages[k] = '0;
      end
      commands_out = 0;
      expected_results.delete();
   endtask

   function automatic stripe_result_type single_result(logic [1:0] kind, logic wr,
                                                       logic [TAG_W-1:0] tag);
      stripe_result_type r;
      r          = '0;
      r.kind     = kind;
      r.is_write = wr;
      r.tag      = tag;
      r.last     = 1'b1;
      return r;
   endfunction

   // Work out the results of one request transfer and queue them
   task automatic predict_event(logic [1:0] op, logic wr, logic [PAGE_W-1:0] start,
                                logic [COUNT_W-1:0] count, logic [TAG_W-1:0] tag);
      int unsigned       limit;
      int unsigned       byte_total;
      logic [31:0]       dice;
      logic [31:0]       page;
      int                i;
      stripe_result_type r;
      limit = (int'(cfg_queue_limit) < QUEUE_SLOTS) ? int'(cfg_queue_limit) : QUEUE_SLOTS;
      case (op)
         OP_HOST_CMD: begin
            if (count == 0 || count > MAX_CMD_PAGES || int'(tag) >= QUEUE_SLOTS ||
                pages_open[tag] != 0) begin
               queue_expected(single_result(KIND_ERROR, 1'b0, tag));
            end else if (commands_out >= limit) begin
               queue_expected(single_result(KIND_REJECT, wr, tag));
            end else begin
               // clamp the die count into the usable range
               dice = 32'(cfg_die_count);
               if (dice == 0) dice = 1;
               if (dice > MAX_DICE) dice = MAX_DICE;
               pages_open[tag] = count;
               slot_write[tag] = wr;
               slot_pages[tag] = count;
               commands_out++;
               for (i = 0; i < count; i++) begin
                  page           = start + 32'(i);
                  r              = '0;
                  r.kind         = KIND_SUB;
                  r.die_num      = DIE_W'(page % dice);
                  r.die_page     = page / dice;
                  r.is_write     = wr;
                  r.tag          = tag;
                  r.last         = (i + 1 == count);
                  queue_expected(r);
               end
            end
         end
         OP_PAGE_DONE: begin
            if (int'(tag) >= QUEUE_SLOTS || pages_open[tag] == 0) begin
               queue_expected(single_result(KIND_ERROR, 1'b0, tag));
            end else begin
               pages_open[tag] = pages_open[tag] - COUNT_W'(1);
               if (pages_open[tag] == 0) begin
                  // last page in: build the completion
                  byte_total = 32'(cfg_header_bytes);
                  if (!slot_write[tag])
                     byte_total += 32'(slot_pages[tag]) * 32'(cfg_page_bytes);
                  r              = single_result(KIND_DONE, slot_write[tag], tag);
                  r.priority_bit = !slot_write[tag];
                  r.return_bytes = RBYTES_W'(byte_total);
                  queue_expected(r);
               end
            end
         end
         OP_RET_SENT: begin
            if (commands_out == 0)
               queue_expected(single_result(KIND_ERROR, 1'b0, tag));
            else
               commands_out--;
         end
         default: begin
            queue_expected(single_result(KIND_ERROR, 1'b0, tag));
         end
      endcase
   endtask

   // Compare one result transfer with the oldest prediction
   task automatic check_result(stripe_result_type got);
      stripe_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected, tag", 32'(got.tag), 32'h0);
      end else begin
         want = expected_results[0];
         expected_results.delete(0);
         if (got.kind != want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.die_num != want.die_num)
            report_mismatch("die_num", 32'(got.die_num), 32'(want.die_num));
         if (got.die_page != want.die_page)
            report_mismatch("die_page", got.die_page, want.die_page);
         if (got.is_write != want.is_write)
            report_mismatch("sub_is_write", 32'(got.is_write), 32'(want.is_write));
         if (got.tag != want.tag)
            report_mismatch("out_tag", 32'(got.tag), 32'(want.tag));
         if (got.priority_bit != want.priority_bit)
            report_mismatch("return_priority", 32'(got.priority_bit),
                            32'(want.priority_bit));
         if (got.return_bytes != want.return_bytes)
            report_mismatch("return_bytes", 32'(got.return_bytes),
                            32'(want.return_bytes));
         if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
      end
   endtask

   // Sample all ports at the edge, then publish the counts
   always @(posedge clock) begin
      stripe_result_type got;
      if (reset) begin
         clear_model();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_DIE_COUNT:    cfg_die_count    = csr_wdata[DCNT_W-1:0];
               CSR_QUEUE_LIMIT:  cfg_queue_limit  = csr_wdata[LIMIT_W-1:0];
               CSR_HEADER_BYTES: cfg_header_bytes = csr_wdata[HDR_W-1:0];
               CSR_PAGE_BYTES:   cfg_page_bytes   = csr_wdata[PBYTES_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind         = rsp_tuser;
            got.die_num      = rsp_tdata[5:0];
            got.die_page     = rsp_tdata[37:6];
            got.is_write     = rsp_tdata[38];
            got.tag          = rsp_tdata[43:39];
            got.priority_bit = rsp_tdata[44];
            got.return_bytes = rsp_tdata[68:45];
            got.last         = rsp_tlast;
            check_result(got);
         end
         if (req_tvalid && req_tready)
            predict_event(req_tuser, req_tdata[0], req_tdata[32:1], req_tdata[39:33],
                          req_tdata[44:40]);
      end
      mismatches <= fail_count;
      pending    <= expected_results.size();
   end

   initial fail_count = 0;

endmodule

// ===== sim/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// Testbench of the page striping command splitter: a short directed run over
// the corner cases, then random phases under several register settings with
// bursty request traffic, a stalling result receiver and one long hold-off.
// -----------------------------------------------------------------------------
module tb;
   import pscs_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          DRAIN_CYCLES   = 50;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;

   typedef struct {
      logic [1:0]          op;
      logic                wr;
      logic [PAGE_W-1:0]   start;
      logic [COUNT_W-1:0]  count;
      logic [TAG_W-1:0]    tag;
   } host_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [71:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatches;
   int                    pending;

   // Stimulus bookkeeping, used only to shape well-formed traffic
   logic [COUNT_W-1:0]    open_left [QUEUE_SLOTS];
   int                    admitted_cnt;
   int                    completed_cnt;
   int                    admit_limit;
   int                    burst_left;
   bit                    hold_start;
   bit                    hold_taken;
   bit                    hold_active;

   page_striping_command_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pscs_result_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic host_event_type make_event(logic [1:0] op, logic wr,
                                                 logic [PAGE_W-1:0] start,
                                                 logic [COUNT_W-1:0] count,
                                                 logic [TAG_W-1:0] tag);
      host_event_type ev;
      ev.op    = op;
      ev.wr    = wr;
      ev.start = start;
      ev.count = count;
      ev.tag   = tag;
      return ev;
   endfunction

   // Track admission and completion as the block should see it
   task automatic note_event(host_event_type ev);
      int cap;
      cap = (admit_limit < QUEUE_SLOTS) ? admit_limit : QUEUE_SLOTS;
      case (ev.op)
         OP_HOST_CMD: begin
            if (ev.count != 0 && ev.count <= MAX_CMD_PAGES && open_left[ev.tag] == 0 &&
                admitted_cnt < cap) begin
               open_left[ev.tag] = ev.count;
               admitted_cnt++;
            end
         end
         OP_PAGE_DONE: begin
            if (open_left[ev.tag] != 0) begin
               open_left[ev.tag] = open_left[ev.tag] - COUNT_W'(1);
               if (open_left[ev.tag] == 0) completed_cnt++;
            end
         end
         OP_RET_SENT: begin
            if (admitted_cnt > 0) begin
               admitted_cnt--;
               if (completed_cnt > 0) completed_cnt--;
            end
         end
         default: ;
      endcase
   endtask

   // Offer one request, hold it until the transfer, then maybe pause
   task automatic send_event(host_event_type ev);
      req_tdata  <= {3'b000, ev.tag, ev.count, ev.start, ev.wr};
      req_tuser  <= ev.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      note_event(ev);
      if (hold_start && (!hold_taken || hold_active)) begin
         // keep offering back to back while the receiver holds off
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 8);
      end
   endtask

   // Mostly well-formed traffic over the open tags, with some noise
   function automatic host_event_type pick_event();
      host_event_type ev;
      int             r;
      int             k;
      int             n_open;
      int             n_free;
      int             open_tags [QUEUE_SLOTS];
      int             free_tags [QUEUE_SLOTS];
      n_open = 0;
      n_free = 0;
      for (k = 0; k < QUEUE_SLOTS; k++) begin
         if (open_left[k] != 0) begin
            open_tags[n_open] = k;
            n_open++;
         end else begin
            free_tags[n_free] = k;
            n_free++;
         end
      end
      ev.wr    = 1'($urandom_range(0, 1));
      ev.start = $urandom;
      ev.count = COUNT_W'($urandom_range(0, 127));
      ev.tag   = TAG_W'($urandom_range(0, QUEUE_SLOTS - 1));
      r = $urandom_range(0, 99);
      if (r >= 75 && r < 90 && completed_cnt == 0 && $urandom_range(0, 3) != 0) r = 0;
      if (r >= 35 && r < 75 && n_open == 0 && $urandom_range(0, 3) != 0) r = 0;
      if (r < 35) begin
         ev.op = OP_HOST_CMD;
         k = $urandom_range(0, 99);
         if (k < 70)      ev.count = COUNT_W'($urandom_range(1, 4));
         else if (k < 92) ev.count = COUNT_W'($urandom_range(5, MAX_CMD_PAGES));
         else if (k < 96) ev.count = COUNT_W'(MAX_CMD_PAGES);
         else             ev.count = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
         k = $urandom_range(0, 3);
         if (k == 0)      ev.start = $urandom_range(0, 255);
         else if (k == 1) ev.start = 32'hFFFF_FFFF - $urandom_range(0, 70);
         if (n_free > 0 && $urandom_range(0, 9) != 0)
            ev.tag = TAG_W'(free_tags[$urandom_range(0, n_free - 1)]);
      end else if (r < 75) begin
         ev.op = OP_PAGE_DONE;
         if (n_open > 0 && $urandom_range(0, 19) != 0)
            ev.tag = TAG_W'(open_tags[$urandom_range(0, n_open - 1)]);
      end else if (r < 90) begin
         ev.op = OP_RET_SENT;
      end else begin
         ev.op = OP_UNUSED;
      end
      return ev;
   endfunction

   // Lower valid and wait until every predicted result has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers, one per cycle
   task automatic program_config(int dice, int limit, int header, int page_bytes);
      csr_wen   <= 1'b1;
      csr_index <= CSR_DIE_COUNT;
      csr_wdata <= CSR_DATA_W'(dice);
      @(posedge clock);
      csr_index <= CSR_QUEUE_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_index <= CSR_HEADER_BYTES;
      csr_wdata <= CSR_DATA_W'(header);
      @(posedge clock);
      csr_index <= CSR_PAGE_BYTES;
      csr_wdata <= CSR_DATA_W'(page_bytes);
      @(posedge clock);
      csr_wen   <= 1'b0;
      admit_limit = limit & 6'h3F;
   endtask

   task automatic run_random(int items);
      int n;
      for (n = 0; n < items; n++) send_event(pick_event());
   endtask

   task automatic run_phase(int dice, int limit, int header, int page_bytes, int items,
                            bit pressure);
      wait_idle();
      program_config(dice, limit, header, page_bytes);
      if (pressure) hold_start = 1'b1;
      run_random(items);
   endtask

   // Receiver: change stall pattern every so often, hold off once on request
   initial begin : receiver
      int   mode;
      int   span;
      int   phase;
      logic ready_next;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(posedge clock);
            if (hold_start && !hold_taken) begin
               hold_taken  = 1'b1;
               hold_active = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_active = 1'b0;
            end
            phase++;
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = (phase % 8) > 2;
            endcase
            rsp_tready <= ready_next;
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Main stimulus
   initial begin : stimulus
      int k;
      for (k = 0; k < QUEUE_SLOTS; k++) open_left[k] = '0;
      admitted_cnt  = 0;
      completed_cnt = 0;
      admit_limit   = 32;
      burst_left    = 0;
      hold_start    = 1'b0;
      hold_taken    = 1'b0;
      hold_active   = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases under the reset settings
      send_event(make_event(OP_HOST_CMD,  1'b0, 32'h0000_0000, 7'd1,  5'd0));
      send_event(make_event(OP_PAGE_DONE, 1'b0, 32'h0,         7'd0,  5'd0));
      send_event(make_event(OP_RET_SENT,  1'b0, 32'h0,         7'd0,  5'd0));
      send_event(make_event(OP_RET_SENT,  1'b1, 32'hFFFF_FFFF, 7'd127, 5'd9));
      send_event(make_event(OP_HOST_CMD,  1'b1, 32'hFFFF_FFE0, 7'd64, 5'd31));
      send_event(make_event(OP_HOST_CMD,  1'b0, 32'h0,         7'd1,  5'd31));
      send_event(make_event(OP_HOST_CMD,  1'b0, 32'h10,        7'd0,  5'd5));
      send_event(make_event(OP_HOST_CMD,  1'b1, 32'h10,        7'd127, 5'd5));
      send_event(make_event(OP_HOST_CMD,  1'b0, 32'h10,        7'd65, 5'd5));
      send_event(make_event(OP_PAGE_DONE, 1'b0, 32'h0,         7'd1,  5'd7));
      send_event(make_event(OP_UNUSED,    1'b1, 32'hFFFF_FFFF, 7'd127, 5'd31));
      send_event(make_event(OP_HOST_CMD,  1'b1, 32'hFFFF_FFFF, 7'd2,  5'd1));
      send_event(make_event(OP_PAGE_DONE, 1'b0, 32'h0,         7'd0,  5'd1));
      send_event(make_event(OP_PAGE_DONE, 1'b0, 32'h0,         7'd0,  5'd1));
      send_event(make_event(OP_RET_SENT,  1'b0, 32'h0,         7'd0,  5'd1));
      send_event(make_event(OP_RET_SENT,  1'b0, 32'h0,         7'd0,  5'd31));
      send_event(make_event(OP_RET_SENT,  1'b0, 32'h0,         7'd0,  5'd2));
      send_event(make_event(OP_HOST_CMD,  1'b0, 32'h8000_0000, 7'd3,  5'd16));
      send_event(make_event(OP_PAGE_DONE, 1'b0, 32'h0,         7'd0,  5'd31));
      send_event(make_event(OP_HOST_CMD,  1'b1, 32'd12345,     7'd1,  5'd2));

      // One die and a queue of one: the next command finds the queue full
      wait_idle();
      program_config(1, 1, 0, 1);
      send_event(make_event(OP_HOST_CMD, 1'b0, 32'd77, 7'd2, 5'd3));
      run_random(15);

      // Random phases over the register range, extremes included
      run_phase(64, 32, 4095, 65536, 50, 1'b1);
      run_phase(3, 2, 100, 512, 35, 1'b0);
      run_phase(0, 5, 7, 0, 30, 1'b0);
      run_phase(127, 63, 4095, 131071, 35, 1'b0);
      run_phase($urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(0, 4095),
                $urandom_range(1, 65536), 35, 1'b0);
      run_phase(5, 0, 1, 3, 15, 1'b0);
      run_phase(8, 32, 16, 4096, 25, 1'b0);

      // Drain and give the verdict
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
